// ===== sv/npc_pkg.sv =====
// Shared types, constants and helper functions for the nearest palette color block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package npc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int FIELD_IDX_W     = 8;
    localparam int CHAN_IN_W       = 10;
    localparam int CHAN_W          = 8;
    localparam int SQ_W            = 2 * CHAN_W;
    // 2*sq + 4*sq + 3*sq stays at or below 9 * 255^2
    localparam int DIST_W          = SQ_W + 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } npc_color_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
    } npc_tag_t;

    // Clamp a signed channel to 0..255.
    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [CHAN_IN_W-1:0] v);
        logic [CHAN_W-1:0] r;
        if (v[CHAN_IN_W-1])
            r = '0;
        else if (v[CHAN_IN_W-2:CHAN_W] != '0)
            r = '1;
        else
            r = v[CHAN_W-1:0];
        return r;
    endfunction

    // Keep the top nibble and widen it back by times 17.
    function automatic logic [CHAN_W-1:0] quant_chan(input logic [CHAN_W-1:0] c);
        return {c[CHAN_W-1:CHAN_W/2], c[CHAN_W-1:CHAN_W/2]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/npc_if.sv =====
// Handshake interfaces for the nearest palette color block: item channel and result channel.
// Depends on npc_pkg for field widths.
`default_nettype none

interface npc_item_if;
    import npc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [FIELD_IDX_W-1:0]        entry_index;
    logic signed [CHAN_IN_W-1:0]   red;
    logic signed [CHAN_IN_W-1:0]   green;
    logic signed [CHAN_IN_W-1:0]   blue;

    modport source (output valid, output operation, output entry_index,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input operation, input entry_index,
                    input red, input green, input blue, output ready);
endinterface

interface npc_result_if;
    import npc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_IDX_W-1:0] color_index;

    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);
endinterface

`default_nettype wire

// ===== sv/npc_dist_unit.sv =====
// Two-stage weighted squared distance unit, shared by every palette entry of a scan.
// Depends on npc_pkg for the color and tag types.
`default_nettype none

module npc_dist_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  npc_pkg::npc_color_t        query,
    input  npc_pkg::npc_color_t        entry,
    input  npc_pkg::npc_tag_t          tag_in,
    output npc_pkg::npc_tag_t          tag_out,
    output logic [npc_pkg::DIST_W-1:0] distance
);
    import npc_pkg::*;

    logic [CHAN_W-1:0] diff_red, diff_green, diff_blue;
    logic [SQ_W-1:0]   sq_red_reg, sq_green_reg, sq_blue_reg;
    npc_tag_t          tag1_reg, tag2_reg;
    logic [DIST_W-1:0] dist_next, dist_reg;

    always_comb
    begin
        diff_red   = (query.red   > entry.red)   ? query.red   - entry.red
                                                 : entry.red   - query.red;
        diff_green = (query.green > entry.green) ? query.green - entry.green
                                                 : entry.green - query.green;
        diff_blue  = (query.blue  > entry.blue)  ? query.blue  - entry.blue
                                                 : entry.blue  - query.blue;
    end

    // weights 2, 4, 3
    assign dist_next = (DIST_W'(sq_red_reg) << 1) + (DIST_W'(sq_green_reg) << 2)
                     + (DIST_W'(sq_blue_reg) << 1) + DIST_W'(sq_blue_reg);

    always_ff @(posedge clk)
    begin
        sq_red_reg   <= SQ_W'(diff_red * diff_red);
        sq_green_reg <= SQ_W'(diff_green * diff_green);
        sq_blue_reg  <= SQ_W'(diff_blue * diff_blue);
        dist_reg     <= dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    assign tag_out  = tag2_reg;
    assign distance = dist_reg;

endmodule

`default_nettype wire

// ===== sv/nearest_palette_color.sv =====
// Nearest palette color search, top level: palette memory, scan sequencer, best-match tracker.
// Depends on npc_pkg, npc_if (item and result interfaces) and npc_dist_unit.
//
// Use: the item channel carries load beats (operation = load) and query beats
// (operation = query). A load beat clamps red/green/blue to 0..255 and writes
// the palette entry named by entry_index; an index beyond the palette is
// dropped. A load gives no result beat.
// A query beat clamps each channel, keeps its top nibble and widens it back
// by 17, then scans every palette entry through the shared distance unit,
// one entry per cycle, for the least 2*dr^2 + 4*dg^2 + 3*db^2; a tie keeps
// the lower index. One result beat with color_index follows.
// Scan path: the scan runs through the single read port of the palette
// memory, read once per cycle, then through the read register and the two
// stages of the distance unit. item.ready is low from the query's acceptance
// until its result loads, so no new beat is taken while a query is in progress.
// Stall: the result sits in an output register until taken, and the block
// takes new beats meanwhile; a later query holds in its final state until
// the output register is free.
// Reset: clears the sequencer and output valid; palette contents are
// undefined until written and must all be loaded before the first query.
`default_nettype none

module nearest_palette_color (
    input  logic  clk,
    input  logic  rst_n,
    npc_item_if.sink     item,
    npc_result_if.source result
);
    import npc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } npc_state_t;

    npc_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    npc_color_t          query_reg;
    npc_color_t          palette_mem [PALETTE_ENTRIES];
    npc_color_t          rd_data_reg;
    npc_tag_t            rd_tag_reg, rd_tag_next;
    npc_tag_t            cmp_tag;
    logic [DIST_W-1:0]   cmp_dist;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                out_valid_reg, out_valid_next;
    logic [FIELD_IDX_W-1:0] out_index_reg;

    logic                accept;
    logic                load_wr;
    logic                query_go;
    logic                last_addr;
    logic                out_load;
    npc_color_t          wr_color;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign load_wr    = accept && (item.operation == OP_LOAD)
                     && ({1'b0, item.entry_index} < (FIELD_IDX_W + 1)'(PALETTE_ENTRIES));
    assign query_go   = accept && (item.operation == OP_QUERY);
    assign last_addr  = (addr_reg == IDX_W'(PALETTE_ENTRIES - 1));
    assign out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    assign wr_color.red   = clamp_chan(item.red);
    assign wr_color.green = clamp_chan(item.green);
    assign wr_color.blue  = clamp_chan(item.blue);

    // Sequencer: issue one palette read per cycle, then let the pipe drain.
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = ST_SCAN;
                    addr_next  = '0;
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (last_addr)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (cmp_tag.valid && cmp_tag.last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_tag_next.valid = (state_reg == ST_SCAN);
        rd_tag_next.last  = last_addr;
        rd_tag_next.index = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rd_tag_reg    <= rd_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Palette memory: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (load_wr)
            palette_mem[item.entry_index[IDX_W-1:0]] <= wr_color;
        rd_data_reg <= palette_mem[addr_reg];
    end

    // Hold the quantized query color for the whole scan.
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            query_reg.red   <= quant_chan(wr_color.red);
            query_reg.green <= quant_chan(wr_color.green);
            query_reg.blue  <= quant_chan(wr_color.blue);
        end
    end

    npc_dist_unit u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .query    (query_reg),
        .entry    (rd_data_reg),
        .tag_in   (rd_tag_reg),
        .tag_out  (cmp_tag),
        .distance (cmp_dist)
    );

    // Track the best entry; strict compare keeps the lowest index on ties.
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (cmp_tag.valid && (cmp_dist < best_dist_reg))
        begin
            best_dist_reg <= cmp_dist;
            best_idx_reg  <= cmp_tag.index;
        end
    end

    // Output register: hold the result until the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_index_reg <= FIELD_IDX_W'(best_idx_reg);
    end

    assign result.valid       = out_valid_reg;
    assign result.color_index = out_index_reg;

endmodule

`default_nettype wire
